[rtl/pal_pkg.sv]
package pal_pkg;

    // Field widths on the stream ports
    localparam int FUNC_BITS      = 3;
    localparam int POS_BITS       = 11;
    localparam int ITEM_BITS      = 12;
    localparam int STAT_BITS      = 2;
    localparam int CNT_OUT_BITS   = 11;
    localparam int IN_TDATA_BITS  = 24;
    localparam int OUT_TDATA_BITS = 24;

    // Defaults for the top-level parameters
    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_HANDLE_BITS = 12;

    // Cells per first-level read-out group
    localparam int GROUP_SIZE = 32;

    // Command codes
    localparam logic [FUNC_BITS-1:0] FN_INS_POS   = 3'd0;
    localparam logic [FUNC_BITS-1:0] FN_INS_FRONT = 3'd1;
    localparam logic [FUNC_BITS-1:0] FN_INS_END   = 3'd2;
    localparam logic [FUNC_BITS-1:0] FN_RMV_POS   = 3'd3;
    localparam logic [FUNC_BITS-1:0] FN_RMV_FRONT = 3'd4;
    localparam logic [FUNC_BITS-1:0] FN_RMV_END   = 3'd5;
    localparam logic [FUNC_BITS-1:0] FN_READ_POS  = 3'd6;
    localparam logic [FUNC_BITS-1:0] FN_NOP       = 3'd7;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_OUT
    } t_state;

    // Broadcast control to every cell
    typedef struct packed {
        logic ins;   // make room at the target, load the new handle there
        logic rem;   // close the gap at the target
        logic tap;   // drive the target's handle onto the read-out tree
    } t_cell_ctrl;

endpackage

[rtl/pal_cell.sv]
module pal_cell #(
    parameter int INDEX       = 0,
    parameter int CNT_BITS    = 11,
    parameter int HANDLE_BITS = 12
) (
    input  logic                   i_clk,
    input  pal_pkg::t_cell_ctrl    i_ctrl,
    input  logic [CNT_BITS-1:0]    i_at,
    input  logic [HANDLE_BITS-1:0] i_item,
    input  logic [HANDLE_BITS-1:0] i_left,
    input  logic [HANDLE_BITS-1:0] i_right,
    output logic [HANDLE_BITS-1:0] o_value,
    output logic [HANDLE_BITS-1:0] o_tap
);
    import pal_pkg::*;

    localparam logic [CNT_BITS-1:0] MY_POS = CNT_BITS'(INDEX);

    logic [HANDLE_BITS-1:0] r_value;
    logic [HANDLE_BITS-1:0] n_value;
    logic                   w_hit;
    logic                   w_after;

    assign w_hit   = (i_at == MY_POS);
    assign w_after = (MY_POS > i_at);

    // Shift toward the end on insert, toward the front on remove
    always_comb begin
        n_value = r_value;
        if (i_ctrl.ins) begin
            if (w_hit) begin
                n_value = i_item;
            end else if (w_after) begin
                n_value = i_left;
            end
        end else if (i_ctrl.rem) begin
            if (w_hit || w_after) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    // Old contents go to the tree, taken the same edge as the shift
    assign o_tap   = (i_ctrl.tap && w_hit) ? r_value : '0;

endmodule

[rtl/positional_array_list.sv]
// Positional array list: an ordered list of record handles held in a row of
// CAPACITY cells, one handle per cell, plus a count. Commands arrive on the
// slave stream (tuser = func, tdata = position, item) and each gives exactly
// one result on the master stream (tuser = status, tdata = item_out,
// count_out). Insert and remove shift every cell from the target onward
// toward its neighbor in the cycle the command is accepted, so any position
// costs the same. For a command, the accept edge shifts the row and latches
// groups of 32 cell taps, the next edge merges the groups into the result
// register, which is then presented. A new command is taken no earlier than
// the cycle the previous result is taken, so the block does not take a new
// command while the two-level registered read-out tree is busy with the last
// one. Cells beyond the count hold arbitrary data after reset and are never
// read; no clearing pass.
module positional_array_list #(
    parameter int CAPACITY    = pal_pkg::DEF_CAPACITY,
    parameter int HANDLE_BITS = pal_pkg::DEF_HANDLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [10:0] position, [22:11] item, [23] zero
    input  logic [pal_pkg::IN_TDATA_BITS-1:0]  i_s_axis_tdata,
    // [2:0] func
    input  logic [pal_pkg::FUNC_BITS-1:0]      i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [11:0] item_out, [22:12] count_out, [23] zero
    output logic [pal_pkg::OUT_TDATA_BITS-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [pal_pkg::STAT_BITS-1:0]      o_m_axis_tuser
);
    import pal_pkg::*;

    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CMP_BITS   = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;
    localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int TAP_SLOTS  = NUM_GROUPS * GROUP_SIZE;
    localparam int PAD_BITS   = OUT_TDATA_BITS - ITEM_BITS - CNT_OUT_BITS;

    t_state                 r_state;
    t_state                 n_state;
    logic [CNT_BITS-1:0]    r_count;
    logic [CNT_BITS-1:0]    n_count;
    t_status                r_status;
    t_status                w_status;
    logic [HANDLE_BITS-1:0] r_grp [NUM_GROUPS];
    logic [HANDLE_BITS-1:0] n_grp [NUM_GROUPS];
    logic [HANDLE_BITS-1:0] r_item_out;
    logic [HANDLE_BITS-1:0] n_item_out;

    logic                   w_in_acc;
    logic                   w_out_acc;
    logic [FUNC_BITS-1:0]   w_func;
    logic [POS_BITS-1:0]    w_pos;
    logic [HANDLE_BITS-1:0] w_item;
    logic [CMP_BITS-1:0]    w_pos_cmp;
    logic [CMP_BITS-1:0]    w_cnt_cmp;
    logic                   w_full;
    logic                   w_empty;
    logic                   w_do_ins;
    logic                   w_do_rem;
    logic                   w_do_tap;
    logic [CNT_BITS-1:0]    w_at;
    t_cell_ctrl             w_ctrl;

    logic [HANDLE_BITS-1:0] w_value [CAPACITY];
    logic [HANDLE_BITS-1:0] w_tap   [TAP_SLOTS];

    // Request fields
    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign w_func    = i_s_axis_tuser;
    assign w_pos     = i_s_axis_tdata[POS_BITS-1:0];
    assign w_item    = HANDLE_BITS'(i_s_axis_tdata[POS_BITS+ITEM_BITS-1:POS_BITS]);
    assign w_pos_cmp = CMP_BITS'(w_pos);
    assign w_cnt_cmp = CMP_BITS'(r_count);
    assign w_full    = (r_count == CNT_BITS'(CAPACITY));
    assign w_empty   = (r_count == '0);

    // Command decode: status checks and target position
    always_comb begin
        w_status = ST_OK;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_do_tap = 1'b0;
        w_at     = '0;
        unique case (w_func) inside
            FN_INS_POS, FN_INS_FRONT, FN_INS_END: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_func == FN_INS_POS && w_pos_cmp > w_cnt_cmp) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_ins = 1'b1;
                    if (w_func == FN_INS_POS) begin
                        w_at = CNT_BITS'(w_pos);
                    end else if (w_func == FN_INS_END) begin
                        w_at = r_count;
                    end
                end
            end
            FN_RMV_POS, FN_RMV_FRONT, FN_RMV_END, FN_READ_POS: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if ((w_func == FN_RMV_POS || w_func == FN_READ_POS)
                             && w_pos_cmp >= w_cnt_cmp) begin
                    w_status = ST_RANGE;
                end else begin
                    w_do_tap = 1'b1;
                    w_do_rem = (w_func != FN_READ_POS);
                    if (w_func == FN_RMV_POS || w_func == FN_READ_POS) begin
                        w_at = CNT_BITS'(w_pos);
                    end else if (w_func == FN_RMV_END) begin
                        w_at = r_count - CNT_BITS'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign w_ctrl.ins = w_in_acc && w_do_ins;
    assign w_ctrl.rem = w_in_acc && w_do_rem;
    assign w_ctrl.tap = w_in_acc && w_do_tap;

    // Count after the command
    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    // Row of cells; the end cells see themselves past the edge
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [HANDLE_BITS-1:0] w_left;
        logic [HANDLE_BITS-1:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = w_value[i];
        end else begin : g_mid_l
            assign w_left = w_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right = w_value[i];
        end else begin : g_mid_r
            assign w_right = w_value[i+1];
        end
        pal_cell #(
            .INDEX       (i),
            .CNT_BITS    (CNT_BITS),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_at    (w_at),
            .i_item  (w_item),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[i]),
            .o_tap   (w_tap[i])
        );
    end

    // Unused tree slots past the last cell
    for (genvar j = CAPACITY; j < TAP_SLOTS; j++) begin : g_pad
        assign w_tap[j] = '0;
    end

    // First tree level: OR within each group
    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                n_grp[g] = n_grp[g] | w_tap[g*GROUP_SIZE+k];
            end
        end
    end

    // Second tree level: OR across groups
    always_comb begin
        n_item_out = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            n_item_out = n_item_out | r_grp[g];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_in_acc) begin
                    n_state = S_REDUCE;
                end else if (w_out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        o_m_axis_tvalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            S_REDUCE: begin
            end
            S_OUT: begin
                o_m_axis_tvalid = 1'b1;
                o_s_axis_tready = i_m_axis_tready;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_status <= w_status;
            r_grp    <= n_grp;
        end
        if (r_state == S_REDUCE) begin
            r_item_out <= n_item_out;
        end
    end

    assign o_m_axis_tdata = {{PAD_BITS{1'b0}}, CNT_OUT_BITS'(r_count),
                             ITEM_BITS'(r_item_out)};
    assign o_m_axis_tuser = r_status;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("count above capacity");

    a_accept_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_REDUCE))
        else $error("accepted request did not start read-out");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_EMPTY) |-> (r_count == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status == ST_FULL) |-> (r_count == CNT_BITS'(CAPACITY)))
        else $error("full status below capacity");

    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_status != ST_OK) |-> (r_item_out == '0))
        else $error("handle returned with flagged status");

endmodule

[verif/pal_checker.sv]
// Watches both streams of the list block, keeps its own copy of the list and
// compares every result against the oldest prediction.
module pal_checker #(
    parameter int CAPACITY = pal_pkg::DEF_CAPACITY
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    // [10:0] position, [22:11] item, [23] zero
    input  logic [pal_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // [2:0] func
    input  logic [pal_pkg::FUNC_BITS-1:0]      i_s_tuser,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    // [11:0] item_out, [22:12] count_out, [23] zero
    input  logic [pal_pkg::OUT_TDATA_BITS-1:0] i_m_tdata,
    // [1:0] status
    input  logic [pal_pkg::STAT_BITS-1:0]      i_m_tuser,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_list_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import pal_pkg::*;

    typedef struct packed {
        logic [ITEM_BITS-1:0]    item;
        t_status                 status;
        logic [CNT_OUT_BITS-1:0] count;
    } t_list_result;

    // Mirror of the list contents and length
    logic [ITEM_BITS-1:0] cells [CAPACITY];
    int                   list_len = 0;
    t_list_result         results_due [$];
    int                   fails = 0;

    // Apply one command to the mirror and return the result it should give
    task automatic list_apply(input logic [FUNC_BITS-1:0] f, input logic [POS_BITS-1:0] p,
                              input logic [ITEM_BITS-1:0] it, output t_list_result r);
        int at;
        int k;
        r.item   = '0;
        r.status = ST_OK;
        at       = -1;
        if (f == FN_INS_POS || f == FN_INS_FRONT || f == FN_INS_END) begin
            if (list_len >= CAPACITY) begin
                // full check wins over the position check
                r.status = ST_FULL;
            end else begin
                case (f)
                    FN_INS_POS:   at = (int'(p) > list_len) ? -1 : int'(p);
                    FN_INS_FRONT: at = 0;
                    default:      at = list_len;
                endcase
                if (at < 0) begin
                    r.status = ST_RANGE;
                end else begin
                    for (k = list_len; k > at; k--)
                        cells[k] = cells[k-1];
                    cells[at] = it;
                    list_len++;
                end
            end
        end else if (f != FN_NOP) begin
            if (list_len == 0) begin
                // empty check wins over the position check
                r.status = ST_EMPTY;
            end else begin
                case (f)
                    FN_RMV_FRONT: at = 0;
                    FN_RMV_END:   at = list_len - 1;
                    default:      at = (int'(p) >= list_len) ? -1 : int'(p);
                endcase
                if (at < 0) begin
                    r.status = ST_RANGE;
                end else begin
                    r.item = cells[at];
                    if (f != FN_READ_POS) begin
                        for (k = at; k + 1 < list_len; k++)
                            cells[k] = cells[k+1];
                        list_len--;
                    end
                end
            end
        end
        r.count = list_len[CNT_OUT_BITS-1:0];
    endtask

    // Predict on each accepted request, compare on each accepted result
    always @(posedge i_clk) begin
        t_list_result want;
        t_list_result got;
        if (!i_rst_n) begin
            list_len = 0;
            results_due.delete();
            for (int k = 0; k < CAPACITY; k++)
                cells[k] = '0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                list_apply(i_s_tuser, i_s_tdata[POS_BITS-1:0],
                           i_s_tdata[POS_BITS +: ITEM_BITS], want);
                results_due.push_back(want);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.item   = i_m_tdata[ITEM_BITS-1:0];
                got.count  = i_m_tdata[ITEM_BITS +: CNT_OUT_BITS];
                got.status = t_status'(i_m_tuser);
                if (results_due.size() == 0) begin
                    $error("result with nothing outstanding: item_out %0h status %0d count %0d",
                           got.item, got.status, got.count);
                    fails++;
                end else begin
                    want = results_due.pop_front();
                    if (got.item !== want.item) begin
                        $error("item_out mismatch: expected %0h, actual %0h",
                               want.item, got.item);
                        fails++;
                    end
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        fails++;
                    end
                    if (got.count !== want.count) begin
                        $error("count_out mismatch: expected %0d, actual %0d",
                               want.count, got.count);
                        fails++;
                    end
                end
            end
        end
        o_fail_count = fails;
        o_pending    = results_due.size();
        o_list_count = list_len;
    end

endmodule

[verif/tb_top.sv]
// Stimulus and verdict for the positional array list.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pal_pkg::*;

    localparam int CAP       = DEF_CAPACITY;
    localparam int HOLD_AT   = 300;   // results seen before the long sink hold-off
    localparam int HOLD_LEN  = 400;   // cycles of the hold-off

    logic                      clk     = 1'b0;
    logic                      rst_n   = 1'b0;
    logic                      s_valid = 1'b0;
    logic [IN_TDATA_BITS-1:0]  s_data  = '0;
    logic [FUNC_BITS-1:0]      s_user  = FN_NOP;
    logic                      m_ready = 1'b0;
    logic                      s_ready;
    logic                      m_valid;
    logic [OUT_TDATA_BITS-1:0] m_data;
    logic [STAT_BITS-1:0]      m_user;

    int fail_count;
    int pending;
    int list_count;
    bit calm      = 1'b0;   // no idling on either side while set
    int seen      = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    positional_array_list dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    pal_checker #(.CAPACITY(CAP)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_list_count (list_count)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Count accepted results for the hold-off trigger
    always @(posedge clk) begin
        if (m_valid && m_ready)
            seen <= seen + 1;
    end

    // Sink: random back-pressure plus one long hold-off
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 36);
            end
        end
    end

    // Offer one request and return at the falling edge after it is taken
    task automatic send_cmd(input logic [FUNC_BITS-1:0] f, input logic [POS_BITS-1:0] p,
                            input logic [ITEM_BITS-1:0] it);
        while (!calm && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= f;
        s_data  <= {1'b0, it, p};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Position near the edges of the legal range, inside it, or anywhere
    function automatic logic [POS_BITS-1:0] pick_pos(input int len, input bit for_insert);
        int top_ok;
        int r;
        top_ok = for_insert ? len : len - 1;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 16)
            return (top_ok < 0) ? '0 : POS_BITS'(top_ok);
        if (r < 22)
            return POS_BITS'(top_ok + 1);
        if (r < 30)
            return POS_BITS'($urandom_range(2047));
        return (top_ok <= 0) ? '0 : POS_BITS'($urandom_range(top_ok));
    endfunction

    function automatic logic [ITEM_BITS-1:0] pick_item();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 10)
            return '1;
        return ITEM_BITS'($urandom);
    endfunction

    // One random request: ins_pct inserts, noise_pct nop or fully random
    task automatic random_cmd(input int ins_pct, input int noise_pct);
        logic [FUNC_BITS-1:0] f;
        int r;
        r = $urandom_range(99);
        if (r < noise_pct) begin
            f = FUNC_BITS'($urandom_range(7));
            if ($urandom_range(1))
                f = FN_NOP;
            send_cmd(f, POS_BITS'($urandom_range(2047)), ITEM_BITS'($urandom));
        end else if (r < noise_pct + ins_pct) begin
            case ($urandom_range(3))
                0, 1:    f = FN_INS_POS;
                2:       f = FN_INS_FRONT;
                default: f = FN_INS_END;
            endcase
            send_cmd(f, pick_pos(list_count, 1'b1), pick_item());
        end else begin
            case ($urandom_range(5))
                0, 1:    f = FN_RMV_POS;
                2:       f = FN_RMV_FRONT;
                3:       f = FN_RMV_END;
                default: f = FN_READ_POS;
            endcase
            send_cmd(f, pick_pos(list_count, 1'b0), pick_item());
        end
    endtask

    initial begin
        int guard;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty list, range edges, every command, nop
        send_cmd(FN_RMV_FRONT, '0, '0);
        send_cmd(FN_RMV_END, '0, '0);
        send_cmd(FN_RMV_POS, '0, '0);
        send_cmd(FN_READ_POS, '0, '0);
        send_cmd(FN_INS_POS, 11'd1, 12'h123);
        send_cmd(FN_INS_POS, 11'h7FF, 12'hFFF);
        send_cmd(FN_NOP, 11'h7FF, 12'hFFF);
        send_cmd(FN_INS_POS, '0, 12'hFFF);
        send_cmd(FN_INS_FRONT, '0, '0);
        send_cmd(FN_INS_END, 11'h7FF, 12'hABC);
        send_cmd(FN_INS_POS, 11'd3, 12'h555);   // position equal to count appends
        send_cmd(FN_INS_POS, 11'd1, 12'hAAA);
        send_cmd(FN_READ_POS, '0, '0);
        send_cmd(FN_READ_POS, 11'd4, '0);
        send_cmd(FN_READ_POS, 11'd5, '0);
        send_cmd(FN_READ_POS, 11'h7FF, '0);
        send_cmd(FN_RMV_POS, 11'd5, '0);
        send_cmd(FN_RMV_POS, 11'd2, '0);
        send_cmd(FN_RMV_FRONT, '0, '0);
        send_cmd(FN_RMV_END, '0, '0);
        send_cmd(FN_NOP, '0, '0);
        send_cmd(FN_RMV_POS, 11'd1, '0);
        send_cmd(FN_READ_POS, '0, '0);

        // Random walk on a short list, in and out of empty
        for (int n = 0; n < 200; n++)
            random_cmd(50, 6);

        // Fill to capacity; the start runs without idling
        guard = 0;
        while (list_count < CAP && guard < 3000) begin
            calm = (guard < 200);
            random_cmd(92, 2);
            guard++;
        end
        calm = 1'b0;

        // Full list: inserts are refused, removes reopen a slot
        for (int n = 0; n < 40; n++)
            random_cmd(60, 4);

        // Shrink from full with mostly removes
        for (int n = 0; n < 380; n++)
            random_cmd(6, 2);

        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
